FILE: hw/rtl/htfa_pkg.sv
// Package for the humidity/temperature frame averager.
// Holds the beat payload types, frame byte positions and scaling constants.
// No dependencies.
package htfa_pkg;

  localparam int RAW_W = 20;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
  } sample_t;

  typedef struct packed {
    logic        [9:0]  humidity_tenths;
    logic signed [11:0] temperature_tenths;
  } result_t;

  // position of the next expected frame byte, idle when no frame is open
  localparam logic [2:0] POS_IDLE     = 3'd0;
  localparam logic [2:0] POS_HUM_HI   = 3'd1;
  localparam logic [2:0] POS_HUM_MID  = 3'd2;
  localparam logic [2:0] POS_SPLIT    = 3'd3;
  localparam logic [2:0] POS_TEMP_MID = 3'd4;
  localparam logic [2:0] POS_TEMP_LO  = 3'd5;
  localparam logic [2:0] POS_LAST     = 3'd6;

  localparam int HUM_SCALE  = 1000;
  localparam int TEMP_SCALE = 2000;

  localparam logic [11:0] TEMP_OFFSET = 12'd500;

endpackage

FILE: hw/rtl/htfa_avg_pipe.sv
// Result pipeline of the frame averager: scales the ring sums to tenths.
// Four elastic stages, the last one is the output register.
// Depends on htfa_pkg.
module htfa_avg_pipe #(
  parameter int AVG_DEPTH = 3
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             sum_valid,
  output logic                                             sum_ready,
  input  logic [htfa_pkg::RAW_W+$clog2(AVG_DEPTH)-1:0]     hum_sum,
  input  logic [htfa_pkg::RAW_W+$clog2(AVG_DEPTH)-1:0]     temp_sum,
  output logic                                             result_valid,
  input  logic                                             result_ready,
  output htfa_pkg::result_t                                result
);

  localparam int SUM_W  = htfa_pkg::RAW_W + $clog2(AVG_DEPTH);
  localparam int PROD_W = SUM_W + 12;
  localparam int Y_W    = PROD_W - htfa_pkg::RAW_W;
  localparam int RS     = Y_W + 3;
  localparam int MUL_W  = Y_W + RS;

  localparam logic [PROD_W-1:0] RND =
    PROD_W'(AVG_DEPTH) << (htfa_pkg::RAW_W - 1);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << RS) / AVG_DEPTH);
  localparam logic [Y_W-1:0]   DEPTH_Y = Y_W'(AVG_DEPTH);

  logic              v1, v2, v3;
  logic              rdy1, rdy2, rdy3, rdy4;
  logic [SUM_W-1:0]  hs1, ts1;
  logic [Y_W-1:0]    hy2, ty2, hy3, ty3, hq3, tq3;
  logic [PROD_W-1:0] hprod, tprod;
  logic [MUL_W-1:0]  hmul, tmul;
  logic [Y_W-1:0]    hrem, trem, hq, tq;

  assign rdy4      = !result_valid || result_ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign sum_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= sum_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) result_valid <= v3;
    end
  end

  // sum * scale + half the divisor, then the power-of-two part of the divide
  always_comb begin
    hprod = PROD_W'(hs1) * PROD_W'(htfa_pkg::HUM_SCALE) + RND;
    tprod = PROD_W'(ts1) * PROD_W'(htfa_pkg::TEMP_SCALE) + RND;
  end

  // reciprocal estimate of y / depth, low by at most one
  always_comb begin
    hmul = MUL_W'(hy2) * RECIP;
    tmul = MUL_W'(ty2) * RECIP;
  end

  // one correction step
  always_comb begin
    hrem = hy3 - hq3 * DEPTH_Y;
    trem = ty3 - tq3 * DEPTH_Y;
    hq   = (hrem >= DEPTH_Y) ? hq3 + Y_W'(1) : hq3;
    tq   = (trem >= DEPTH_Y) ? tq3 + Y_W'(1) : tq3;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      hs1 <= hum_sum;
      ts1 <= temp_sum;
    end
    if (rdy2) begin
      hy2 <= hprod[PROD_W-1:htfa_pkg::RAW_W];
      ty2 <= tprod[PROD_W-1:htfa_pkg::RAW_W];
    end
    if (rdy3) begin
      hy3 <= hy2;
      ty3 <= ty2;
      hq3 <= hmul[MUL_W-1:RS];
      tq3 <= tmul[MUL_W-1:RS];
    end
    if (rdy4) begin
      result.humidity_tenths    <= hq[9:0];
      result.temperature_tenths <= $signed(tq[11:0] - htfa_pkg::TEMP_OFFSET);
    end
  end

endmodule

FILE: hw/rtl/humidity_temperature_frame_averager_top.sv
// Humidity/temperature frame averager: takes sensor frame bytes one per beat,
// keeps running sums over the last AVG_DEPTH frames and emits the averages
// in tenths of a percent and tenths of a degree once AVG_DEPTH frames are in.
// Takes one beat every cycle while sample_ready is high. A frame (flag beat plus
// six bytes) that completes with full rings gives one result through a
// four-stage scaling pipeline whose first register loads on the edge that takes
// its last byte; sample_ready drops only when that pipeline is full behind a
// stalled result. Ring sums are kept as running totals, so no pass over the
// rings is needed per result.
// Depends on htfa_pkg and htfa_avg_pipe.
module humidity_temperature_frame_averager_top #(
  parameter int AVG_DEPTH = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  htfa_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output htfa_pkg::result_t result
);

  localparam int SUM_W  = htfa_pkg::RAW_W + $clog2(AVG_DEPTH);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);

  logic [2:0]                  pos;
  logic [htfa_pkg::RAW_W-1:0]  hum_asm, temp_asm;
  logic [htfa_pkg::RAW_W-1:0]  hum_ring  [AVG_DEPTH];
  logic [htfa_pkg::RAW_W-1:0]  temp_ring [AVG_DEPTH];
  logic [SLOT_W-1:0]           slot;
  logic [CNT_W-1:0]            seen;
  logic [SUM_W-1:0]            hum_sum, temp_sum, hum_sum_next, temp_sum_next;

  logic accept, frame_done, full, emit;

  assign accept     = sample_valid && sample_ready;
  assign frame_done = accept && !sample.frame_first && (pos == htfa_pkg::POS_LAST);
  assign full       = (seen == CNT_W'(AVG_DEPTH));
  assign emit       = frame_done && (full || (seen == CNT_W'(AVG_DEPTH - 1)));

  // once the rings are full the slot being written holds the oldest frame
  always_comb begin
    hum_sum_next  = hum_sum + SUM_W'(hum_asm)
                  - (full ? SUM_W'(hum_ring[slot]) : SUM_W'(0));
    temp_sum_next = temp_sum + SUM_W'(temp_asm)
                  - (full ? SUM_W'(temp_ring[slot]) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= htfa_pkg::POS_IDLE;
      hum_asm  <= '0;
      temp_asm <= '0;
      slot     <= '0;
      seen     <= '0;
      hum_sum  <= '0;
      temp_sum <= '0;
    end else if (accept) begin
      if (sample.frame_first) begin
        pos <= htfa_pkg::POS_HUM_HI;
      end else begin
        case (pos)
          htfa_pkg::POS_HUM_HI: begin
            hum_asm[19:12] <= sample.rx_byte;
            pos            <= htfa_pkg::POS_HUM_MID;
          end
          htfa_pkg::POS_HUM_MID: begin
            hum_asm[11:4] <= sample.rx_byte;
            pos           <= htfa_pkg::POS_SPLIT;
          end
          htfa_pkg::POS_SPLIT: begin
            hum_asm[3:0]    <= sample.rx_byte[7:4];
            temp_asm[19:16] <= sample.rx_byte[3:0];
            pos             <= htfa_pkg::POS_TEMP_MID;
          end
          htfa_pkg::POS_TEMP_MID: begin
            temp_asm[15:8] <= sample.rx_byte;
            pos            <= htfa_pkg::POS_TEMP_LO;
          end
          htfa_pkg::POS_TEMP_LO: begin
            temp_asm[7:0] <= sample.rx_byte;
            pos           <= htfa_pkg::POS_LAST;
          end
          htfa_pkg::POS_LAST: begin
            pos      <= htfa_pkg::POS_IDLE;
            hum_sum  <= hum_sum_next;
            temp_sum <= temp_sum_next;
            slot     <= (slot == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
            if (!full) seen <= seen + CNT_W'(1);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      hum_ring[slot]  <= hum_asm;
      temp_ring[slot] <= temp_asm;
    end
  end

  htfa_avg_pipe #(
    .AVG_DEPTH(AVG_DEPTH)
  ) u_avg_pipe (
    .clk         (clk),
    .rst         (rst),
    .sum_valid   (emit),
    .sum_ready   (sample_ready),
    .hum_sum     (hum_sum_next),
    .temp_sum    (temp_sum_next),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

FILE: hw/rtl/htfa_checker.sv
// Port-level checks for the humidity/temperature frame averager.
// Bound to the top level; depends on htfa_pkg.
module htfa_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input htfa_pkg::sample_t sample,
  input logic              result_valid,
  input logic              result_ready,
  input htfa_pkg::result_t result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // with the output register empty the whole pipeline drains, so input is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample_ready low with no result pending");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.humidity_tenths <= 10'd1000)
    else $error("humidity average out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.temperature_tenths >= -12'sd500) &&
                     (result.temperature_tenths <= 12'sd1500))
    else $error("temperature average out of range");

endmodule

bind humidity_temperature_frame_averager_top htfa_checker u_htfa_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .sample      (sample),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .result      (result)
);
